@@ src/cap_pkg.sv @@
// cap_pkg: shared types and constants for the cell address parser.
// No dependencies; used by every other file in src.
`default_nettype none

package cap_pkg;

    // parse phases
    localparam logic [1:0] PH_LETTERS = 2'd0;
    localparam logic [1:0] PH_DIGITS  = 2'd1;
    localparam logic [1:0] PH_ERROR   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_LIMIT = 2'd0;
    localparam logic [1:0] REG_COL_LIMIT = 2'd1;

    // field widths
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 21;
    localparam int COL_W  = 15;
    localparam int IDX_W  = 2;

    // character codes and bases
    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
    localparam int                COL_BASE = 26;
    localparam int                ROW_BASE = 10;

    // reset values of the limit registers
    localparam logic [ROW_W-1:0] ROW_LIMIT_RST = 21'd1048576;
    localparam logic [COL_W-1:0] COL_LIMIT_RST = 15'd16384;

    // saturation limits
    localparam logic [ROW_W-1:0] ROW_SAT = {ROW_W{1'b1}};
    localparam logic [COL_W-1:0] COL_SAT = {COL_W{1'b1}};

    // registered input character handed from the input stage to the parser
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] code;
    } char_stage_t;

    // address limits handed to the parser
    typedef struct packed {
        logic [ROW_W-1:0] row_limit;
        logic [COL_W-1:0] col_limit;
    } limits_t;

endpackage

`default_nettype wire

@@ src/cap_if.sv @@
// cap_char_if / cap_result_if: valid/ready channels of the cell address parser.
// Depends on cap_pkg for field widths.
`default_nettype none

interface cap_char_if;
    logic                      valid;
    logic                      ready;
    logic [cap_pkg::CHAR_W-1:0] char_code;
    logic                      last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cap_result_if;
    logic                      valid;
    logic                      ready;
    logic [cap_pkg::ROW_W-1:0] row_number;
    logic [cap_pkg::COL_W-1:0] column_number;
    logic                      invalid;

    modport source (output valid, output row_number, output column_number,
                    output invalid, input ready);
    modport sink   (input valid, input row_number, input column_number,
                    input invalid, output ready);
endinterface

`default_nettype wire

@@ src/cap_in_stage.sv @@
// cap_in_stage: input register for the character channel.
// Depends on cap_pkg and cap_char_if.
`default_nettype none

module cap_in_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    cap_char_if.sink          char_stream,
    input  wire logic         advance,
    output cap_pkg::char_stage_t stage
);

    logic                       valid_reg;
    logic                       last_reg;
    logic [cap_pkg::CHAR_W-1:0] code_reg;
    logic                       take;

    // room when empty or when the held transaction moves on this cycle
    assign char_stream.ready = !valid_reg || advance;
    assign take              = char_stream.valid && char_stream.ready;

    // control: occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (char_stream.ready)
        begin
            valid_reg <= char_stream.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg <= char_stream.last_char;
            code_reg <= char_stream.char_code;
        end
    end

    assign stage = {valid_reg, last_reg, code_reg};

endmodule

`default_nettype wire

@@ src/cap_parse.sv @@
// cap_parse: accumulator state and result register of the cell address parser.
// Depends on cap_pkg and cap_result_if.
`default_nettype none

module cap_parse (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cap_pkg::char_stage_t stage,
    input  wire cap_pkg::limits_t     limits,
    output logic                      advance,
    cap_result_if.source              result
);

    localparam int COL_SUM_W = cap_pkg::COL_W + 6;
    localparam int ROW_SUM_W = cap_pkg::ROW_W + 4;

    logic [1:0]                phase_reg, phase_next;
    logic [cap_pkg::COL_W-1:0] col_reg, col_next;
    logic [cap_pkg::ROW_W-1:0] row_reg, row_next;
    logic                      ovf_reg, ovf_next;

    logic                      out_valid_reg;
    logic [cap_pkg::ROW_W-1:0] out_row_reg;
    logic [cap_pkg::COL_W-1:0] out_col_reg;
    logic                      out_invalid_reg;

    logic                      is_letter;
    logic                      is_digit;
    logic [COL_SUM_W-1:0]      col_sum;
    logic [ROW_SUM_W-1:0]      row_sum;
    logic [cap_pkg::COL_W-1:0] col_sat;
    logic [cap_pkg::ROW_W-1:0] row_sat;
    logic                      col_ovf;
    logic                      row_ovf;
    logic                      fire;
    logic                      emit;
    logic                      bad;

    // a final character needs the result register free
    assign advance = !stage.last || !out_valid_reg || result.ready;
    assign fire    = stage.valid && advance;
    assign emit    = fire && stage.last;

    // character classes
    assign is_letter = (stage.code >= cap_pkg::CH_A) && (stage.code <= cap_pkg::CH_Z);
    assign is_digit  = (stage.code >= cap_pkg::CH_0) && (stage.code <= cap_pkg::CH_9);

    // column: acc * 26 + letter value, saturating
    assign col_sum = {{(COL_SUM_W-cap_pkg::COL_W){1'b0}}, col_reg}
                     * COL_SUM_W'(cap_pkg::COL_BASE)
                     + COL_SUM_W'(stage.code - cap_pkg::CH_A + 8'd1);
    assign col_ovf = col_sum > COL_SUM_W'(cap_pkg::COL_SAT);
    assign col_sat = col_ovf ? cap_pkg::COL_SAT : col_sum[cap_pkg::COL_W-1:0];

    // row: acc * 10 + digit value, saturating
    assign row_sum = {{(ROW_SUM_W-cap_pkg::ROW_W){1'b0}}, row_reg}
                     * ROW_SUM_W'(cap_pkg::ROW_BASE)
                     + ROW_SUM_W'(stage.code - cap_pkg::CH_0);
    assign row_ovf = row_sum > ROW_SUM_W'(cap_pkg::ROW_SAT);
    assign row_sat = row_ovf ? cap_pkg::ROW_SAT : row_sum[cap_pkg::ROW_W-1:0];

    // next parse state for the character in the input register
    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ovf_next   = ovf_reg;
        unique case (phase_reg)
            cap_pkg::PH_LETTERS:
            begin
                if (is_letter)
                begin
                    col_next = col_sat;
                    ovf_next = ovf_reg || col_ovf;
                end
                else if (is_digit && (col_reg != '0))
                begin
                    phase_next = cap_pkg::PH_DIGITS;
                    row_next   = row_sat;
                    ovf_next   = ovf_reg || row_ovf;
                end
                else
                begin
                    phase_next = cap_pkg::PH_ERROR;
                end
            end
            cap_pkg::PH_DIGITS:
            begin
                if (is_digit)
                begin
                    row_next = row_sat;
                    ovf_next = ovf_reg || row_ovf;
                end
                else
                begin
                    phase_next = cap_pkg::PH_ERROR;
                end
            end
            default:
            begin
                phase_next = cap_pkg::PH_ERROR;
            end
        endcase
    end

    // validity of the finished address
    assign bad = (phase_next != cap_pkg::PH_DIGITS) || ovf_next ||
                 (row_next == '0) || (row_next > limits.row_limit) ||
                 (col_next == '0) || (col_next > limits.col_limit);

    // parse state, cleared after each final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cap_pkg::PH_LETTERS;
            col_reg   <= '0;
            row_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (emit)
        begin
            phase_reg <= cap_pkg::PH_LETTERS;
            col_reg   <= '0;
            row_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ovf_reg   <= ovf_next;
        end
    end

    // result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register: payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg     <= bad ? '0 : row_next;
            out_col_reg     <= bad ? '0 : col_next;
            out_invalid_reg <= bad;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.row_number    = out_row_reg;
    assign result.column_number = out_col_reg;
    assign result.invalid       = out_invalid_reg;

endmodule

`default_nettype wire

@@ src/cell_address_parser_core.sv @@
// cell_address_parser_core: top level of the A1 cell address parser.
// Depends on cap_pkg, cap_if, cap_in_stage and cap_parse.
`default_nettype none

// Takes an A1-style address one ASCII character per transaction on
// char_stream, the final character flagged by last_char, and returns one
// transaction on result per address with row, column and an invalid flag
// (row and column read zero when invalid). One character is accepted every
// cycle while the input register can move on; the rate is set by the
// combinational multiply-add that updates the column or row accumulator
// in the parse stage. A result is offered once its final character has
// passed the input register and the parse stage; input keeps flowing while
// a result waits, but a second final character holds in the input register
// until the pending result is taken. The user writes the row limit
// (index 0) and column limit (index 1) via cfg_we/cfg_index/cfg_data only
// while idle, which the block does not enforce; other indexes are ignored.
module cell_address_parser_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    cap_char_if.sink                          char_stream,
    cap_result_if.source                      result,
    input  wire logic                         cfg_we,
    input  wire logic [cap_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [cap_pkg::ROW_W-1:0]    cfg_data
);

    logic [cap_pkg::ROW_W-1:0] row_limit_reg;
    logic [cap_pkg::COL_W-1:0] col_limit_reg;
    cap_pkg::char_stage_t      stage;
    cap_pkg::limits_t          limits;
    logic                      advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= cap_pkg::ROW_LIMIT_RST;
            col_limit_reg <= cap_pkg::COL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cap_pkg::REG_ROW_LIMIT)
            begin
                row_limit_reg <= cfg_data;
            end
            else if (cfg_index == cap_pkg::REG_COL_LIMIT)
            begin
                col_limit_reg <= cfg_data[cap_pkg::COL_W-1:0];
            end
        end
    end

    assign limits = {row_limit_reg, col_limit_reg};

    // input register
    cap_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream),
        .advance     (advance),
        .stage       (stage)
    );

    // accumulators and result register
    cap_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .limits  (limits),
        .advance (advance),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ src/cap_checker.sv @@
// cap_checker: port-level assertions for cell_address_parser_core, bound to it.
// Depends on cap_pkg for field widths.
`default_nettype none

module cap_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [cap_pkg::ROW_W-1:0] out_row,
    input wire logic [cap_pkg::COL_W-1:0] out_col,
    input wire logic                      out_invalid
);

    // no result during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) &&
                                    $stable(out_invalid))
        else $error("result payload changed while stalled");

    // invalid addresses report zero coordinates, valid ones nonzero
    a_coords: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_invalid ? (out_row == '0 && out_col == '0)
                                   : (out_row != '0 && out_col != '0)))
        else $error("result coordinates disagree with invalid flag");

endmodule

bind cell_address_parser_core cap_checker u_cap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_row     (result.row_number),
    .out_col     (result.column_number),
    .out_invalid (result.invalid)
);

`default_nettype wire
